@@ hw/rtl/bcev_pkg.sv @@
// Package for the B-spline curve evaluator: sizes, operation and register
// codes, and the divider status type. No dependencies.
package bcev_pkg;

   localparam int MAX_CONTROL_POINTS = 64;
   localparam int MAX_DEGREE         = 7;
   localparam int DIMENSIONS         = 3;
   localparam int FRACTION_BITS      = 16;

   localparam int KNOT_DEPTH = MAX_CONTROL_POINTS + MAX_DEGREE + 1;
   localparam int CTRL_DEPTH = MAX_CONTROL_POINTS * DIMENSIONS;
   localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
   localparam int CTRL_AW    = $clog2(CTRL_DEPTH);
   localparam int KNOT_W     = FRACTION_BITS + 1;

   // Divider operand widths: signed dividend and knot difference.
   localparam int DVD_W = 56;
   localparam int DSR_W = KNOT_W + 1;

   localparam logic [1:0] OP_LOAD_KNOT = 2'd0;
   localparam logic [1:0] OP_LOAD_CTRL = 2'd1;
   localparam logic [1:0] OP_EVALUATE  = 2'd2;

   localparam logic CSR_DEGREE    = 1'b0;
   localparam logic CSR_LAST_CTRL = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
      logic clipped;
   } bcev_div_status_type;

endpackage

@@ hw/rtl/bcev_if.sv @@
// Channel interfaces of the B-spline curve evaluator: request, result and
// register write. Depends on bcev_pkg.
interface bcev_req_if;
   import bcev_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [6:0]          table_index;
   logic [1:0]          coordinate;
   logic signed [31:0]  load_value;
   logic [KNOT_W-1:0]   param_u;
   logic [2:0]          deriv_order;
   modport source (output valid, operation, table_index, coordinate, load_value,
                   param_u, deriv_order, input ready);
   modport sink (input valid, operation, table_index, coordinate, load_value,
                 param_u, deriv_order, output ready);
endinterface

interface bcev_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          coord_index;
   logic signed [31:0]  coord_value;
   logic                saturated;
   logic                last_coord;
   modport source (output valid, coord_index, coord_value, saturated, last_coord,
                   input ready);
   modport sink (input valid, coord_index, coord_value, saturated, last_coord,
                 output ready);
endinterface

interface bcev_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [5:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bspline_curve_evaluator.sv @@
// Top level of the B-spline curve evaluator: knot and control stores, the
// evaluation sequencer and the shared multiplier. Depends on bcev_pkg,
// bcev_if and bcev_div.
//
// Channel   Direction  Beat
// req_if    in         load knot, load control coordinate, or evaluate
// rsp_if    out        one coordinate of an evaluation, three per evaluate
// csr_if    in         write of degree or last control index
//
// A load is written into its store when it is accepted. An evaluate runs the
// span search, then per coordinate reads the p+1 control coordinates of the
// span, runs the k(2p-k+1)/2 derivative and (p-k)(p-k+1)/2 de Boor steps, each
// through the divider unless its knot span is zero, and hands over the beat.
// A single item is in work at a time.
// Reset is synchronous and clears control state only; stores need loading.
// A stalled result holds the sequencer until the beat is taken.
module bspline_curve_evaluator (
   input  logic        clock,
   input  logic        reset,
   bcev_req_if.sink    req_if,
   bcev_rsp_if.source  rsp_if,
   bcev_csr_if.sink    csr_if
);
   import bcev_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_SPAN_RD  = 5'd1;
   localparam logic [4:0] S_SPAN_CHK = 5'd2;
   localparam logic [4:0] S_W_RD     = 5'd3;
   localparam logic [4:0] S_W_WR     = 5'd4;
   localparam logic [4:0] S_DA       = 5'd5;
   localparam logic [4:0] S_DB       = 5'd6;
   localparam logic [4:0] S_DC       = 5'd7;
   localparam logic [4:0] S_DD       = 5'd8;
   localparam logic [4:0] S_DE       = 5'd9;
   localparam logic [4:0] S_DF       = 5'd10;
   localparam logic [4:0] S_BA       = 5'd11;
   localparam logic [4:0] S_BB       = 5'd12;
   localparam logic [4:0] S_BC       = 5'd13;
   localparam logic [4:0] S_BD       = 5'd14;
   localparam logic [4:0] S_BE       = 5'd15;
   localparam logic [4:0] S_BF       = 5'd16;
   localparam logic [4:0] S_DIV      = 5'd17;
   localparam logic [4:0] S_WB       = 5'd18;
   localparam logic [4:0] S_EMIT     = 5'd19;
   localparam logic [4:0] S_ZERO     = 5'd20;

   localparam int PROD_W = 52;

   // Configuration registers.
   logic [2:0] degree_ff, degree_in;
   logic [5:0] last_ff, last_in;

   // Sequencer state.
   logic [4:0] state_ff, state_in;
   logic [2:0] p_ff, p_in;
   logic [5:0] n_ff, n_in;
   logic [2:0] k_ff, k_in;
   logic [2:0] q_ff, q_in;
   logic [KNOT_W-1:0] u_ff, u_in;
   logic [5:0] l_ff, l_in;
   logic [1:0] c_ff, c_in;
   logic [2:0] t_ff, t_in;
   logic [2:0] r_ff, r_in;
   logic       sat_ff, sat_in;
   logic       deriv_ff, deriv_in;

   // Arithmetic datapath registers.
   logic [KNOT_W-1:0]        ka_ff, ka_in;
   logic signed [DSR_W-1:0]  den_ff, den_in;
   logic signed [DSR_W-1:0]  num_ff, num_in;
   logic signed [31:0]       wa_ff, wa_in;
   logic signed [32:0]       mul_a_ff, mul_a_in;
   logic signed [DSR_W:0]    mul_b_ff, mul_b_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_index_ff, rsp_index_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic              rsp_sat_ff, rsp_sat_in;
   logic              rsp_last_ff, rsp_last_in;

   // Stores and the working point array.
   logic [KNOT_W-1:0]  knot_mem_ff [KNOT_DEPTH];
   logic signed [31:0] ctrl_mem_ff [CTRL_DEPTH];
   logic signed [31:0] w_ff [MAX_DEGREE+1];
   logic [KNOT_W-1:0]  knot_rd_ff;
   logic signed [31:0] ctrl_rd_ff;

   logic [KNOT_AW-1:0] knot_addr;
   logic [CTRL_AW-1:0] ctrl_addr;
   logic [CTRL_AW-1:0] ctrl_wr_addr;
   logic               knot_wr_en;
   logic               ctrl_wr_en;
   logic [2:0]         w_rd_idx;
   logic signed [31:0] w_rd;
   logic               w_wr_en;
   logic signed [31:0] w_wr_data;

   logic [2:0] p_eff;
   logic [5:0] n_eff;
   logic [5:0] base;
   logic [6:0] item_idx;
   logic       req_fire;
   logic       rsp_free;
   logic       div_start;
   logic signed [DVD_W-1:0] div_dividend;
   logic signed [31:0]      div_quotient;
   bcev_div_status_type     div_status;

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.coord_index = rsp_index_ff;
   assign rsp_if.coord_value = rsp_value_ff;
   assign rsp_if.saturated   = rsp_sat_ff;
   assign rsp_if.last_coord  = rsp_last_ff;

   // Clamp the configured degree and last control index.
   assign p_eff = (degree_ff == 3'd0) ? 3'd1 : degree_ff;
   assign n_eff = (last_ff < {3'b000, p_eff}) ? {3'b000, p_eff} : last_ff;
   assign base  = l_ff - {3'b000, q_ff};
   assign item_idx = {1'b0, base} + {4'b0000, t_ff};
   assign w_rd  = w_ff[w_rd_idx];

   assign knot_wr_en = req_fire && (req_if.operation == OP_LOAD_KNOT)
                       && (req_if.table_index < 7'(KNOT_DEPTH));
   assign ctrl_wr_en = req_fire && (req_if.operation == OP_LOAD_CTRL)
                       && (req_if.table_index < 7'(MAX_CONTROL_POINTS))
                       && (req_if.coordinate < 2'(DIMENSIONS));
   assign ctrl_wr_addr = CTRL_AW'(req_if.table_index) * CTRL_AW'(DIMENSIONS)
                         + CTRL_AW'(req_if.coordinate);

   // Store read addresses and working array read index by state.
   always_comb begin
      knot_addr = '0;
      w_rd_idx  = t_ff;
      case (state_ff)
         S_SPAN_RD: knot_addr = KNOT_AW'({1'b0, l_ff} + 7'd1 + {4'b0000, k_ff});
         S_DA:      knot_addr = KNOT_AW'(item_idx + {4'b0000, p_ff} + 7'd1);
         S_DB:      knot_addr = KNOT_AW'(item_idx + {4'b0000, r_ff});
         S_BA:      knot_addr = KNOT_AW'(item_idx + {4'b0000, k_ff});
         S_BB:      knot_addr = KNOT_AW'(item_idx + {4'b0000, q_ff} + 7'd1
                                         - {4'b0000, r_ff} + {4'b0000, k_ff});
         default:   knot_addr = '0;
      endcase
      case (state_ff)
         S_DC:    w_rd_idx = t_ff + 3'd1;
         S_BC:    w_rd_idx = t_ff - 3'd1;
         S_EMIT:  w_rd_idx = q_ff;
         default: w_rd_idx = t_ff;
      endcase
   end
   assign ctrl_addr = CTRL_AW'(item_idx[5:0]) * CTRL_AW'(DIMENSIONS) + CTRL_AW'(c_ff);

   // Sequencer and datapath next state.
   always_comb begin
      degree_in    = degree_ff;
      last_in      = last_ff;
      state_in     = state_ff;
      p_in = p_ff; n_in = n_ff; k_in = k_ff; q_in = q_ff; u_in = u_ff;
      l_in = l_ff; c_in = c_ff; t_in = t_ff; r_in = r_ff;
      sat_in       = sat_ff;
      deriv_in     = deriv_ff;
      ka_in = ka_ff; den_in = den_ff; num_in = num_ff; wa_in = wa_ff;
      mul_a_in = mul_a_ff; mul_b_in = mul_b_ff; acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      w_wr_en      = 1'b0;
      w_wr_data    = '0;
      div_start    = 1'b0;
      div_dividend = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes.
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DEGREE:    degree_in = csr_if.data[2:0];
            CSR_LAST_CTRL: last_in = csr_if.data;
            default:       degree_in = degree_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_if.operation == OP_EVALUATE)) begin
               p_in = p_eff;
               n_in = n_eff;
               k_in = req_if.deriv_order;
               u_in = req_if.param_u;
               q_in = p_eff - req_if.deriv_order;
               l_in = {3'b000, p_eff - req_if.deriv_order};
               c_in = 2'd0;
               state_in = (req_if.deriv_order > p_eff) ? S_ZERO : S_SPAN_RD;
            end
         end
         // Span search: walk l up while u is at or beyond the next knot.
         S_SPAN_RD: begin
            if (({1'b0, l_ff} + 7'd1) < ({1'b0, n_ff} + 7'd1 - {4'b0000, k_ff})) begin
               state_in = S_SPAN_CHK;
            end else begin
               t_in = 3'd0; sat_in = 1'b0; state_in = S_W_RD;
            end
         end
         S_SPAN_CHK: begin
            if (u_ff >= knot_rd_ff) begin
               l_in = l_ff + 6'd1; state_in = S_SPAN_RD;
            end else begin
               t_in = 3'd0; sat_in = 1'b0; state_in = S_W_RD;
            end
         end
         // Fetch the p+1 control coordinates of this span.
         S_W_RD: state_in = S_W_WR;
         S_W_WR: begin
            w_wr_en = 1'b1; w_wr_data = ctrl_rd_ff;
            if (t_ff == p_ff) begin
               if (k_ff != 3'd0) begin
                  r_in = 3'd1; t_in = 3'd0; deriv_in = 1'b1; state_in = S_DA;
               end else if (q_ff != 3'd0) begin
                  r_in = 3'd1; t_in = q_ff; deriv_in = 1'b0; state_in = S_BA;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               t_in = t_ff + 3'd1; state_in = S_W_RD;
            end
         end
         // Derivative difference step.
         S_DA: state_in = S_DB;
         S_DB: begin ka_in = knot_rd_ff; state_in = S_DC; end
         S_DC: begin
            den_in = $signed({1'b0, ka_ff}) - $signed({1'b0, knot_rd_ff});
            wa_in  = w_rd;
            state_in = S_DD;
         end
         S_DD: begin
            if (den_ff == '0) begin
               w_wr_en = 1'b1; w_wr_data = '0; state_in = S_WB;
            end else begin
               mul_a_in = 33'(wa_ff) - 33'(w_rd);
               mul_b_in = $signed({1'b0, 15'd0, p_ff - r_ff + 3'd1});
               state_in = S_DE;
            end
         end
         S_DE: state_in = S_DF;
         S_DF: begin
            div_start    = 1'b1;
            div_dividend = {prod_ff[DVD_W-FRACTION_BITS-1:0], FRACTION_BITS'(0)};
            state_in     = S_DIV;
         end
         // De Boor blending step.
         S_BA: state_in = S_BB;
         S_BB: begin ka_in = knot_rd_ff; state_in = S_BC; end
         S_BC: begin
            den_in = $signed({1'b0, knot_rd_ff}) - $signed({1'b0, ka_ff});
            num_in = $signed({1'b0, u_ff}) - $signed({1'b0, ka_ff});
            if (knot_rd_ff == ka_ff) begin
               w_wr_en = 1'b1; w_wr_data = w_rd; state_in = S_WB;
            end else begin
               mul_a_in = 33'(w_rd);
               mul_b_in = (DSR_W+1)'($signed({1'b0, knot_rd_ff}))
                          - (DSR_W+1)'($signed({1'b0, u_ff}));
               state_in = S_BD;
            end
         end
         S_BD: begin
            mul_a_in = 33'(w_rd);
            mul_b_in = (DSR_W+1)'(num_ff);
            state_in = S_BE;
         end
         S_BE: begin acc_in = prod_ff; state_in = S_BF; end
         S_BF: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(acc_ff) + DVD_W'(prod_ff);
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               w_wr_en   = 1'b1;
               w_wr_data = div_quotient;
               sat_in    = sat_ff | div_status.clipped;
               state_in  = S_WB;
            end
         end
         // Step the triangle indices.
         S_WB: begin
            if (deriv_ff) begin
               if (({1'b0, t_ff} + 4'd1 + {1'b0, r_ff}) <= {1'b0, p_ff}) begin
                  t_in = t_ff + 3'd1; state_in = S_DA;
               end else if (r_ff < k_ff) begin
                  r_in = r_ff + 3'd1; t_in = 3'd0; state_in = S_DA;
               end else if (q_ff != 3'd0) begin
                  r_in = 3'd1; t_in = q_ff; deriv_in = 1'b0; state_in = S_BA;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               if (t_ff > r_ff) begin
                  t_in = t_ff - 3'd1; state_in = S_BA;
               end else if (r_ff < q_ff) begin
                  r_in = r_ff + 3'd1; t_in = q_ff; state_in = S_BA;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         // Hand one coordinate to the result register.
         S_EMIT, S_ZERO: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = c_ff;
               rsp_value_in = (state_ff == S_EMIT) ? w_rd : 32'sd0;
               rsp_sat_in   = (state_ff == S_EMIT) ? sat_ff : 1'b0;
               rsp_last_in  = (c_ff == 2'(DIMENSIONS - 1));
               if (c_ff == 2'(DIMENSIONS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  c_in = c_ff + 2'd1;
                  t_in = 3'd0;
                  sat_in = 1'b0;
                  if (state_ff == S_EMIT) begin
                     state_in = S_W_RD;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= 3'd3;
         last_ff      <= 6'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff <= p_in; n_ff <= n_in; k_ff <= k_in; q_ff <= q_in; u_ff <= u_in;
      l_ff <= l_in; c_ff <= c_in; t_ff <= t_in; r_ff <= r_in;
      sat_ff <= sat_in; deriv_ff <= deriv_in;
      ka_ff <= ka_in; den_ff <= den_in; num_ff <= num_in; wa_ff <= wa_in;
      mul_a_ff <= mul_a_in; mul_b_ff <= mul_b_in; acc_ff <= acc_in;
      prod_ff <= PROD_W'(mul_a_ff * mul_b_ff);
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Knot store: one write, one registered read.
   always_ff @(posedge clock) begin
      if (knot_wr_en) begin
         knot_mem_ff[KNOT_AW'(req_if.table_index)] <= req_if.load_value[KNOT_W-1:0];
      end
      knot_rd_ff <= (knot_addr < KNOT_AW'(KNOT_DEPTH)) ? knot_mem_ff[knot_addr] : '0;
   end

   // Control store: one write, one registered read.
   always_ff @(posedge clock) begin
      if (ctrl_wr_en) begin
         ctrl_mem_ff[ctrl_wr_addr] <= req_if.load_value;
      end
      ctrl_rd_ff <= ctrl_mem_ff[ctrl_addr];
   end

   // Working points of the current triangle.
   always_ff @(posedge clock) begin
      if (w_wr_en) begin
         w_ff[t_ff] <= w_wr_data;
      end
   end

   bcev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // The divider never starts on a zero knot span.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (den_ff != '0))
      else $error("divider started with zero divisor");

   // While waiting on a quotient the divider is working or finishing.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_status.busy || div_status.done))
      else $error("sequencer waits on an idle divider");

   // The final beat of an evaluation carries the last coordinate number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == 2'(DIMENSIONS - 1)))
      else $error("last flag on wrong coordinate");

endmodule

@@ hw/rtl/bcev_div.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating
// toward zero and clipping the quotient to signed 32 bits. Depends on bcev_pkg.
module bcev_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [bcev_pkg::DVD_W-1:0] dividend,
   input  logic signed [bcev_pkg::DSR_W-1:0] divisor,
   output logic signed [31:0]                quotient,
   output bcev_pkg::bcev_div_status_type     status
);
   import bcev_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DSR_W:0]   trial;
   logic [DVD_W-1:0] big_pos;
   logic [DVD_W-1:0] big_neg;

   // One shift-subtract step per cycle while busy.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DVD_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         dsr_in  = divisor[DSR_W-1] ? DSR_W'(-divisor) : DSR_W'(divisor);
         neg_in  = dividend[DVD_W-1] ^ divisor[DSR_W-1];
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DSR_W]) begin
            rem_in = trial[DSR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DSR_W-2:0], quo_ff[DVD_W-1]};
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // Apply the sign and clip the magnitude to the signed 32-bit range.
   assign big_pos = DVD_W'(32'h7FFF_FFFF);
   assign big_neg = DVD_W'(33'h0_8000_0000);

   always_comb begin
      status.busy    = busy_ff;
      status.done    = done_ff;
      status.clipped = 1'b0;
      if (neg_ff) begin
         if (quo_ff > big_neg) begin
            quotient       = 32'sh8000_0000;
            status.clipped = 1'b1;
         end else begin
            quotient = -$signed(quo_ff[31:0]);
         end
      end else begin
         if (quo_ff > big_pos) begin
            quotient       = 32'sh7FFF_FFFF;
            status.clipped = 1'b1;
         end else begin
            quotient = $signed(quo_ff[31:0]);
         end
      end
   end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for bspline_curve_evaluator: drives loads, evaluates
// and register writes, predicts every coordinate beat and checks it.
// Depends on bcev_pkg, the bcev_if channel interfaces and the RTL top.
`timescale 1ns / 1ps

module testbench;
   import bcev_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NUM_PHASES = 5;
   localparam int EVALS_PER_PHASE = 12;
   localparam int SETTLE_CYCLES = 64;
   // Largest last index and degree used below set how much of the stores is read.
   localparam int CTRL_POINTS_USED = 11;
   localparam int KNOTS_USED = 18;

   typedef struct {
      logic [1:0]  op;
      logic [6:0]  idx;
      logic [1:0]  coord;
      logic [31:0] val;
      logic [16:0] u;
      logic [2:0]  order;
      bit          zero_result;
   } stim_row_type;

   typedef struct {
      logic [1:0]  coord_index;
      logic [31:0] coord_value;
      logic        saturated;
      logic        last_coord;
   } coord_result_type;

   logic clock;
   logic reset;

   bcev_req_if req_if ();
   bcev_rsp_if rsp_if ();
   bcev_csr_if csr_if ();

   bspline_curve_evaluator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Shadow copy of the stores and registers.
   logic [KNOT_W-1:0] knot_mem [KNOT_DEPTH];
   logic [31:0]       ctrl_mem [CTRL_DEPTH];
   int                cfg_degree;
   int                cfg_last;

   coord_result_type expected_coords [$];
   int errors;
   int evals_sent;
   int loads_sent;
   int sat_seen;
   int burst_left;
   bit gaps_on;
   logic [15:0] ready_mask;
   int cycle_count;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Timeout.
   initial begin
      #400_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver stall pattern.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_if.ready <= ready_mask[cycle_count % 16];
   end

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      coord_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_coords.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat coord %0d value %h", $time,
                     rsp_if.coord_index, rsp_if.coord_value);
         end else begin
            want = expected_coords.pop_front();
            if (rsp_if.saturated) sat_seen++;
            if (rsp_if.coord_index !== want.coord_index ||
                rsp_if.coord_value !== want.coord_value ||
                rsp_if.saturated !== want.saturated ||
                rsp_if.last_coord !== want.last_coord) begin
               errors++;
               $display("%0t: mismatch expected idx %0d val %h sat %0d last %0d",
                        $time, want.coord_index, want.coord_value, want.saturated,
                        want.last_coord);
               $display("%0t:          actual   idx %0d val %h sat %0d last %0d",
                        $time, rsp_if.coord_index, rsp_if.coord_value,
                        rsp_if.saturated, rsp_if.last_coord);
            end
         end
      end
   end

   function automatic longint clip32(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint knot_val(int i);
      if (i >= KNOT_DEPTH) return 0;
      return longint'({15'd0, knot_mem[i]});
   endfunction

   function automatic longint ctrl_val(int pt, int c);
      return longint'($signed(ctrl_mem[pt * DIMENSIONS + c]));
   endfunction

   // Appends one expected beat at the tail of the queue.
   function automatic void expect_coord(coord_result_type res);
      expected_coords.insert(expected_coords.size(), res);
   endfunction

   function automatic void push_zero_coords();
      coord_result_type res;
      for (int c = 0; c < DIMENSIONS; c++) begin
         res.coord_index = c[1:0];
         res.coord_value = '0;
         res.saturated   = 1'b0;
         res.last_coord  = (c == DIMENSIONS - 1);
         expect_coord(res);
      end
   endfunction

   // Derivative differences followed by the de Boor triangle, per coordinate.
   function automatic void predict_curve_point(logic [16:0] u_in, logic [2:0] order);
      int p, n, k, q, l, base, i, j;
      longint u, d, num, den, tj;
      longint w [8];
      bit sat;
      coord_result_type res;
      p = cfg_degree;
      if (p < 1) p = 1;
      if (p > MAX_DEGREE) p = MAX_DEGREE;
      n = cfg_last;
      if (n < p) n = p;
      k = order;
      u = longint'({47'd0, u_in});
      if (k > p) begin
         push_zero_coords();
         return;
      end
      q = p - k;
      l = q;
      while (l + 1 < n + 1 - k && u >= knot_val(l + 1 + k)) l++;
      base = l - q;
      for (int c = 0; c < DIMENSIONS; c++) begin
         sat = 1'b0;
         for (int t = 0; t <= p; t++) w[t] = ctrl_val(base + t, c);
         for (int r = 1; r <= k; r++) begin
            for (int t = 0; t + r <= p; t++) begin
               i = base + t;
               d = knot_val(i + p + 1) - knot_val(i + r);
               if (d == 0) begin
                  w[t] = 0;
               end else begin
                  num = longint'(p - r + 1) * (w[t + 1] - w[t]) * 64'sd65536;
                  w[t] = clip32(num / d, sat);
               end
            end
         end
         for (int r = 1; r <= q; r++) begin
            for (int t = q; t >= r; t--) begin
               j = l - q + t;
               tj = knot_val(j + k);
               den = knot_val(j + q + 1 - r + k) - tj;
               num = u - tj;
               if (den == 0) w[t] = w[t - 1];
               else w[t] = clip32((w[t - 1] * (den - num) + w[t] * num) / den, sat);
            end
         end
         res.coord_index = c[1:0];
         res.coord_value = w[q][31:0];
         res.saturated   = sat;
         res.last_coord  = (c == DIMENSIONS - 1);
         expect_coord(res);
      end
   endfunction

   // Sends one beat, honoring burst gaps, then updates the shadow state.
   task automatic send_item(stim_row_type row);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.operation   <= row.op;
      req_if.table_index <= row.idx;
      req_if.coordinate  <= row.coord;
      req_if.load_value  <= row.val;
      req_if.param_u     <= row.u;
      req_if.deriv_order <= row.order;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (row.op)
         OP_LOAD_KNOT: begin
            loads_sent++;
            if (row.idx < KNOT_DEPTH) knot_mem[row.idx] = row.val[KNOT_W-1:0];
         end
         OP_LOAD_CTRL: begin
            loads_sent++;
            if (row.idx < MAX_CONTROL_POINTS && row.coord < DIMENSIONS)
               ctrl_mem[row.idx * DIMENSIONS + row.coord] = row.val;
         end
         OP_EVALUATE: begin
            evals_sent++;
            if (row.zero_result) push_zero_coords();
            else predict_curve_point(row.u, row.order);
         end
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [5:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (index == CSR_DEGREE) cfg_degree = data[2:0];
      else cfg_last = data;
      @(posedge clock);
   endtask

   function automatic stim_row_type make_row(logic [1:0] op, int idx, int coord,
                                             logic [31:0] val, int u, int order);
      stim_row_type row;
      row.op = op;
      row.idx = idx[6:0];
      row.coord = coord[1:0];
      row.val = val;
      row.u = u[16:0];
      row.order = order[2:0];
      row.zero_result = 1'b0;
      return row;
   endfunction

   // Sorted knot vector with occasional repeats; upper load bits are noise.
   task automatic fill_knots(int count);
      int cur;
      cur = 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) != 0) cur += $urandom_range(0, 4000);
         if (cur > 65536) cur = 65536;
         send_item(make_row(OP_LOAD_KNOT, i, $urandom_range(0, 3),
                            {15'($urandom), 17'(cur)}, $urandom, $urandom));
      end
   endtask

   function automatic logic [31:0] rand_coord_value();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 2 ** 21)) - (2 ** 20));
   endfunction

   // Random item: mostly evaluations, then loads, ignored items as noise.
   function automatic stim_row_type random_row();
      int pick, order;
      int u;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         order = ($urandom_range(0, 4) != 0) ?
                 $urandom_range(0, (cfg_degree < 1) ? 1 : cfg_degree) : $urandom_range(0, 7);
         u = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 65536) : $urandom_range(0, 131071);
         return make_row(OP_EVALUATE, $urandom, $urandom, $urandom, u, order);
      end
      if (pick < 85)
         return make_row(OP_LOAD_CTRL, $urandom_range(0, 63), $urandom_range(0, 2),
                         rand_coord_value(), $urandom, $urandom);
      if (pick < 90)
         return make_row(OP_LOAD_KNOT, $urandom_range(0, 71), $urandom, $urandom,
                         $urandom, $urandom);
      if (pick < 95)
         return make_row(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      return make_row(2'($urandom_range(0, 1)), $urandom_range(72, 127), 3, $urandom,
                      $urandom, $urandom);
   endfunction

   stim_row_type directed_rows [23];
   int phase_degree [NUM_PHASES] = '{3, 0, 7, 1, 5};
   int phase_last   [NUM_PHASES] = '{3, 0, 10, 10, 8};

   initial begin
      int evals_done;
      req_if.valid = 1'b0;
      req_if.operation = OP_LOAD_KNOT;
      req_if.table_index = '0;
      req_if.coordinate = '0;
      req_if.load_value = '0;
      req_if.param_u = '0;
      req_if.deriv_order = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_DEGREE;
      csr_if.data = '0;
      rsp_if.ready = 1'b1;
      ready_mask = 16'hFFFF;
      cycle_count = 0;
      errors = 0;
      evals_sent = 0;
      loads_sent = 0;
      sat_seen = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      cfg_degree = 3;
      cfg_last = 3;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every entry that the register settings below can reach.
      fill_knots(KNOTS_USED);
      for (int i = 0; i < CTRL_POINTS_USED * DIMENSIONS; i++)
         send_item(make_row(OP_LOAD_CTRL, i / DIMENSIONS, i % DIMENSIONS,
                            rand_coord_value(), $urandom, $urandom));

      // Directed part at the reset register values (degree 3, last index 3).
      directed_rows = '{
         make_row(OP_EVALUATE, 0, 0, 0, 0, 0),
         make_row(OP_EVALUATE, 0, 0, 0, 65536, 0),
         make_row(OP_EVALUATE, 127, 3, 32'hFFFF_FFFF, 131071, 0),
         make_row(OP_EVALUATE, 0, 0, 0, 32768, 1),
         make_row(OP_EVALUATE, 0, 0, 0, 40000, 3),
         make_row(OP_EVALUATE, 0, 0, 0, 12345, 4),
         make_row(OP_EVALUATE, 0, 0, 0, 65536, 7),
         make_row(OP_UNUSED, 3, 1, 32'h1234_5678, 100, 1),
         make_row(OP_LOAD_KNOT, 127, 0, 32'hFFFF_FFFF, 0, 0),
         make_row(OP_LOAD_CTRL, 64, 0, 32'h5555_5555, 0, 0),
         make_row(OP_LOAD_CTRL, 5, 3, 32'hAAAA_AAAA, 0, 0),
         make_row(OP_LOAD_CTRL, 0, 0, 32'h7FFF_FFFF, 0, 0),
         make_row(OP_LOAD_CTRL, 1, 0, 32'h8000_0000, 0, 0),
         make_row(OP_LOAD_CTRL, 2, 1, 32'h8000_0000, 0, 0),
         make_row(OP_LOAD_CTRL, 3, 2, 32'h7FFF_FFFF, 0, 0),
         make_row(OP_EVALUATE, 0, 0, 0, 20000, 1),
         make_row(OP_LOAD_KNOT, 3, 0, 32'd30000, 0, 0),
         make_row(OP_LOAD_KNOT, 4, 0, 32'd30000, 0, 0),
         make_row(OP_LOAD_KNOT, 5, 0, 32'd30000, 0, 0),
         make_row(OP_EVALUATE, 0, 0, 0, 30000, 2),
         make_row(OP_EVALUATE, 0, 0, 0, 30000, 0),
         make_row(OP_LOAD_KNOT, 4, 0, 32'hFFFE_0001, 0, 0),
         make_row(OP_EVALUATE, 0, 0, 0, 50000, 1)
      };
      // Orders above the degree come out as zeros.
      directed_rows[5].zero_result = 1'b1;
      directed_rows[6].zero_result = 1'b1;
      foreach (directed_rows[i]) send_item(directed_rows[i]);
      drain_results();

      // Random phases, each under its own register setting and stall pattern.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            write_reg(CSR_DEGREE, 6'(phase_degree[ph]));
            write_reg(CSR_LAST_CTRL, 6'(phase_last[ph]));
         end
         gaps_on = (ph % 3) != 1;
         ready_mask = (ph % 4 == 2) ? 16'hFFFF : 16'($urandom) | 16'h0101;
         evals_done = 0;
         while (evals_done < EVALS_PER_PHASE) begin
            stim_row_type row;
            row = random_row();
            send_item(row);
            if (row.op == OP_EVALUATE) evals_done++;
            // Hold the sender once mid-phase until the results catch up.
            if (evals_done == EVALS_PER_PHASE / 2 && row.op == OP_EVALUATE) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (expected_coords.size() != 0) @(posedge clock);
               burst_left = 0;
            end
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d evaluations and %0d loads over %0d register settings;",
               evals_sent, loads_sent, NUM_PHASES);
      $display("%0d result beats came back saturated.", sat_seen);
      if (errors == 0 && expected_coords.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/bcev_pkg.sv
hw/rtl/bcev_if.sv
hw/rtl/bcev_div.sv
hw/rtl/bspline_curve_evaluator.sv
tb/testbench.sv
